[rtl/core/twsg_pkg.sv]
package twsg_pkg;

   localparam int MUL_W     = 32;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int FX_BITS   = 30;
   localparam int CNT_W     = 17;
   localparam int LEN_W     = 16;
   localparam int IDX_W     = 16;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMPLITUDE,
      CSR_SAMPLE_COUNT,
      CSR_TAPER_LENGTH,
      CSR_SINE_STEP,
      CSR_TAPER_STEP
   } twsg_csr_type;

   typedef enum logic [1:0] {
      WIN_FLAT,
      WIN_RISE,
      WIN_FALL
   } twsg_win_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_BUSY,
      T_HOLD
   } twsg_top_state_type;

   typedef enum logic [3:0] {
      E_IDLE,
      E_LOAD,
      E_SQ,
      E_SQ_USE,
      E_HORN,
      E_HORN_USE,
      E_FIN,
      E_FIN_USE,
      E_OFFS,
      E_PHI,
      E_AMP1,
      E_AMP1_USE,
      E_AMP2,
      E_AMP2_USE
   } twsg_eng_state_type;

   typedef struct packed {
      logic         go;
      twsg_win_type win;
   } twsg_ctl_type;

   typedef struct packed {
      logic done;
   } twsg_sts_type;

   // Odd polynomial coefficients of the quarter-wave sine, Q2.30, in Horner order.
   function automatic logic [MUL_W-1:0] twsg_coef(input logic [2:0] k);
      logic [MUL_W-1:0] c;
      case (k)
         3'd0:    c = 32'd3864;
         3'd1:    c = 32'd172272;
         3'd2:    c = 32'd5026995;
         3'd3:    c = 32'd85569306;
         3'd4:    c = 32'd693598668;
         3'd5:    c = 32'd1686629713;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

[rtl/core/twsg_req_if.sv]
interface twsg_req_if;
   logic valid;
   logic ready;
   logic start_req;

   modport source (output valid, output start_req, input ready);
   modport sink (input valid, input start_req, output ready);
endinterface

[rtl/core/twsg_rsp_if.sv]
interface twsg_rsp_if #(
   parameter int VALUE_BITS = 24
);
   import twsg_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] sample;
   logic [VALUE_BITS-2:0]        envelope;
   logic [IDX_W-1:0]             sample_index;
   logic                         last;

   modport source (output valid, output sample, output envelope, output sample_index,
                   output last, input ready);
   modport sink (input valid, input sample, input envelope, input sample_index,
                 input last, output ready);
endinterface

[rtl/core/tukey_windowed_sine_generator_core.sv]
// An accepted tick in a run gives one result beat; the rising taper takes longer than
// a flat window and the falling taper longer still. All products share one 32x32
// multiplier; the falling taper adds a 17-step shift-add. A new tick is taken no
// sooner than the cycle after each result is loaded, so none is taken while a sample is
// in work or held for a stalled output. Ticks outside a run are taken but give no beat.
// Reset is synchronous: it ends any run, loads register defaults and empties the output.
module tukey_windowed_sine_generator_core #(
   parameter int MAX_SAMPLES = 65536,
   parameter int PHASE_BITS  = 32,
   parameter int VALUE_BITS  = 24,
   localparam int CSR_W0 = (PHASE_BITS > VALUE_BITS) ? PHASE_BITS : VALUE_BITS,
   localparam int CSR_W  = (CSR_W0 > twsg_pkg::CNT_W) ? CSR_W0 : twsg_pkg::CNT_W
) (
   input  logic                           clock,
   input  logic                           reset,
   twsg_req_if.sink                       req_chan,
   twsg_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [twsg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]               csr_wdata
);
   import twsg_pkg::*;

   localparam int F = VALUE_BITS - 2;
   localparam logic [24:0] MAX_S = 25'(MAX_SAMPLES);
   localparam logic [VALUE_BITS-2:0] ONE = {1'b1, {F{1'b0}}};

   logic signed [VALUE_BITS-1:0] amplitude_ff;
   logic [CNT_W-1:0]             sample_count_ff;
   logic [LEN_W-1:0]             taper_length_ff;
   logic [PHASE_BITS-1:0]        sine_step_ff;
   logic [PHASE_BITS-1:0]        taper_step_ff;

   twsg_top_state_type state_ff, state_in;

   logic                  running_ff, running_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [PHASE_BITS-1:0] sph_ff, sph_in;
   logic [PHASE_BITS-1:0] tph_ff, tph_in;

   logic [PHASE_BITS-1:0] job_sph_ff;
   logic [PHASE_BITS-1:0] job_tph_ff;
   logic [IDX_W-1:0]      job_idx_ff;
   logic                  job_last_ff;
   twsg_win_type          job_win_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_BITS-1:0] rsp_sample_ff;
   logic [VALUE_BITS-2:0]        rsp_env_ff;
   logic [IDX_W-1:0]             rsp_idx_ff;
   logic                         rsp_last_ff;

   logic                  accept;
   logic                  eff_run;
   logic [CNT_W-1:0]      eff_pos;
   logic [PHASE_BITS-1:0] eff_sph;
   logic [PHASE_BITS-1:0] eff_tph;
   logic [CNT_W-1:0]      nc_pre;
   logic [CNT_W-1:0]      n_count;
   logic [CNT_W-1:0]      count_m1;
   logic                  is_last;
   twsg_win_type          win;
   logic                  rsp_load;

   twsg_ctl_type          ctl;
   twsg_sts_type          sts;
   logic signed [VALUE_BITS-1:0] eng_sample;
   logic [VALUE_BITS-2:0]        eng_env;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff    <= '0;
         sample_count_ff <= CNT_W'(2);
         taper_length_ff <= '0;
         sine_step_ff    <= '0;
         taper_step_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_AMPLITUDE:    amplitude_ff    <= csr_wdata[VALUE_BITS-1:0];
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_TAPER_LENGTH: taper_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_SINE_STEP:    sine_step_ff    <= csr_wdata[PHASE_BITS-1:0];
            CSR_TAPER_STEP:   taper_step_ff   <= csr_wdata[PHASE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign nc_pre   = (sample_count_ff == '0) ? CNT_W'(1) : sample_count_ff;
   assign n_count  = ({8'b0, nc_pre} > MAX_S) ? MAX_S[CNT_W-1:0] : nc_pre;
   assign count_m1 = n_count - 1'b1;

   assign accept  = req_chan.valid && req_chan.ready;
   assign eff_run = req_chan.start_req || running_ff;
   assign eff_pos = req_chan.start_req ? '0 : pos_ff;
   assign eff_sph = req_chan.start_req ? '0 : sph_ff;
   assign eff_tph = req_chan.start_req ? '0 : tph_ff;
   assign is_last = eff_pos >= count_m1;

   // The rising taper wins where the two tapers overlap.
   always_comb begin
      if (eff_pos < CNT_W'(taper_length_ff)) begin
         win = WIN_RISE;
      end else if (({1'b0, eff_pos} + (CNT_W+1)'(taper_length_ff)) >= {1'b0, n_count}) begin
         win = WIN_FALL;
      end else begin
         win = WIN_FLAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         running_ff   <= 1'b0;
         pos_ff       <= '0;
         sph_ff       <= '0;
         tph_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         pos_ff       <= pos_in;
         sph_ff       <= sph_in;
         tph_ff       <= tph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && eff_run) begin
         job_sph_ff  <= eff_sph;
         job_tph_ff  <= eff_tph;
         job_idx_ff  <= eff_pos[IDX_W-1:0];
         job_last_ff <= is_last;
         job_win_ff  <= win;
      end
      if (rsp_load) begin
         rsp_sample_ff <= eng_sample;
         rsp_env_ff    <= eng_env;
         rsp_idx_ff    <= job_idx_ff;
         rsp_last_ff   <= job_last_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      running_in     = running_ff;
      pos_in         = pos_ff;
      sph_in         = sph_ff;
      tph_in         = tph_ff;
      rsp_load       = 1'b0;
      req_chan.ready = 1'b0;
      ctl.go         = 1'b0;
      ctl.win        = job_win_ff;
      case (state_ff)
         T_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid && eff_run) begin
               ctl.go   = 1'b1;
               state_in = T_BUSY;
               if (is_last) begin
                  running_in = 1'b0;
                  pos_in     = '0;
                  sph_in     = '0;
                  tph_in     = '0;
               end else begin
                  running_in = 1'b1;
                  pos_in     = eff_pos + 1'b1;
                  sph_in     = eff_sph + sine_step_ff;
                  tph_in     = eff_tph + taper_step_ff;
               end
            end
         end
         T_BUSY: begin
            if (sts.done) begin
               state_in = T_HOLD;
            end
         end
         T_HOLD: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   twsg_engine #(
      .PHASE_BITS (PHASE_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .sine_phase  (job_sph_ff),
      .taper_phase (job_tph_ff),
      .taper_step  (taper_step_ff),
      .count_m1    (count_m1),
      .amplitude   (amplitude_ff),
      .sample      (eng_sample),
      .envelope    (eng_env)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample       = rsp_sample_ff;
   assign rsp_chan.envelope     = rsp_env_ff;
   assign rsp_chan.sample_index = rsp_idx_ff;
   assign rsp_chan.last         = rsp_last_ff;

   a_env_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_env_ff <= ONE)
      else $error("window value above unity");

   a_sample_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff != {1'b1, {(VALUE_BITS-1){1'b0}}})
      else $error("sample not saturated to the symmetric range");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      sts.done && job_last_ff |-> !running_ff)
      else $error("run still marked active after its last sample");

   a_done_in_busy: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> state_ff == T_BUSY)
      else $error("engine finished outside a busy period");

endmodule

[rtl/core/twsg_mul.sv]
module twsg_mul (
   input  logic                        clock,
   input  logic [twsg_pkg::MUL_W-1:0]  mul_a,
   input  logic [twsg_pkg::MUL_W-1:0]  mul_b,
   output logic [twsg_pkg::PROD_W-1:0] prod
);
   import twsg_pkg::*;

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign prod = prod_ff;

endmodule

[rtl/core/twsg_engine.sv]
module twsg_engine #(
   parameter int PHASE_BITS = 32,
   parameter int VALUE_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  twsg_pkg::twsg_ctl_type         ctl,
   output twsg_pkg::twsg_sts_type         sts,
   input  logic [PHASE_BITS-1:0]          sine_phase,
   input  logic [PHASE_BITS-1:0]          taper_phase,
   input  logic [PHASE_BITS-1:0]          taper_step,
   input  logic [twsg_pkg::CNT_W-1:0]     count_m1,
   input  logic signed [VALUE_BITS-1:0]   amplitude,
   output logic signed [VALUE_BITS-1:0]   sample,
   output logic [VALUE_BITS-2:0]          envelope
);
   import twsg_pkg::*;

   localparam int F     = VALUE_BITS - 2;
   localparam int QBITS = PHASE_BITS - 2;
   localparam int SH    = FX_BITS - F;
   localparam int BIT_W = $clog2(CNT_W);
   localparam logic [PROD_W-1:0] S_HALF = (64'd1 << SH) >> 1;
   localparam logic [PROD_W-1:0] R_HALF = (64'd1 << F) >> 1;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
   localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {QBITS{1'b0}}};
   localparam logic [FX_BITS:0] FULL_Q = {1'b1, {FX_BITS{1'b0}}};

   twsg_eng_state_type state_ff, state_in;

   logic                  pass_ff, pass_in;
   logic [FX_BITS:0]      x_ff, x_in;
   logic [1:0]            q_ff, q_in;
   logic [FX_BITS:0]      x2_ff, x2_in;
   logic [MUL_W-1:0]      p_ff, p_in;
   logic [2:0]            k_ff, k_in;
   logic [F:0]            smag_ff, smag_in;
   logic                  sneg_ff, sneg_in;
   logic [F:0]            w_ff, w_in;
   logic [VALUE_BITS-1:0] m_ff, m_in;
   logic [PHASE_BITS-1:0] acc_ff, acc_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [PHASE_BITS-1:0] cph_ff, cph_in;
   logic [VALUE_BITS-1:0] sample_ff, sample_in;

   logic [MUL_W-1:0]        mul_a, mul_b;
   logic [PROD_W-1:0]       prod;
   logic [PHASE_BITS-1:0]   ph_sel;
   logic [QBITS+FX_BITS-1:0] f_wide;
   logic [FX_BITS-1:0]      f30;
   logic [FX_BITS:0]        x_new;
   logic [MUL_W-1:0]        s_full;
   logic [PROD_W-1:0]       s_rnd;
   logic [F:0]              s_mag;
   logic                    fin_neg;
   logic [F+1:0]            w_sum;
   logic [F:0]              w_diff;
   logic [F:0]              w_calc;
   logic [VALUE_BITS-1:0]   amag;
   logic [PROD_W-1:0]       rnd;
   logic [VALUE_BITS-1:0]   r_mag;
   logic                    neg_out;
   logic [PHASE_BITS-1:0]   acc_next;

   twsg_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // Phase to quarter-wave argument: keep the top 30 fraction bits of the quadrant, mirrored in odd quadrants.
   assign ph_sel = pass_ff ? cph_ff : sine_phase;
   assign f_wide = {ph_sel[QBITS-1:0], {FX_BITS{1'b0}}};
   assign f30    = f_wide[QBITS+FX_BITS-1:QBITS];
   assign x_new  = ph_sel[QBITS] ? (FULL_Q - {1'b0, f30}) : {1'b0, f30};

   assign s_full  = prod[FX_BITS+MUL_W-1:FX_BITS];
   assign s_rnd   = ({32'b0, s_full} + S_HALF) >> SH;
   assign s_mag   = (s_rnd > PROD_W'(ONE)) ? ONE : s_rnd[F:0];
   assign fin_neg = q_ff[1] && (s_mag != '0);

   assign w_sum  = {1'b0, ONE} + {1'b0, s_mag};
   assign w_diff = ONE - s_mag;
   assign w_calc = fin_neg ? w_sum[F+1:1] : {1'b0, w_diff[F:1]};

   assign amag    = amplitude[VALUE_BITS-1] ? (~amplitude + 1'b1) : amplitude;
   assign rnd     = (prod + R_HALF) >> F;
   assign r_mag   = (rnd > PROD_W'(VMAX)) ? VMAX : rnd[VALUE_BITS-1:0];
   assign neg_out = amplitude[VALUE_BITS-1] ^ sneg_ff;

   // MSB-first shift-add of (N-1) times the taper step, modulo one turn.
   assign acc_next = {acc_ff[PHASE_BITS-2:0], 1'b0} + (count_m1[bit_ff] ? taper_step : '0);

   always_comb begin
      case (state_ff)
         E_SQ: begin
            mul_a = MUL_W'(x_ff);
            mul_b = MUL_W'(x_ff);
         end
         E_HORN: begin
            mul_a = MUL_W'(x2_ff);
            mul_b = p_ff;
         end
         E_FIN: begin
            mul_a = MUL_W'(x_ff);
            mul_b = p_ff;
         end
         E_AMP1: begin
            mul_a = MUL_W'(amag);
            mul_b = MUL_W'(smag_ff);
         end
         E_AMP2: begin
            mul_a = MUL_W'(m_ff);
            mul_b = MUL_W'(w_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff   <= pass_in;
      x_ff      <= x_in;
      q_ff      <= q_in;
      x2_ff     <= x2_in;
      p_ff      <= p_in;
      k_ff      <= k_in;
      smag_ff   <= smag_in;
      sneg_ff   <= sneg_in;
      w_ff      <= w_in;
      m_ff      <= m_in;
      acc_ff    <= acc_in;
      bit_ff    <= bit_in;
      cph_ff    <= cph_in;
      sample_ff <= sample_in;
   end

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      x_in      = x_ff;
      q_in      = q_ff;
      x2_in     = x2_ff;
      p_in      = p_ff;
      k_in      = k_ff;
      smag_in   = smag_ff;
      sneg_in   = sneg_ff;
      w_in      = w_ff;
      m_in      = m_ff;
      acc_in    = acc_ff;
      bit_in    = bit_ff;
      cph_in    = cph_ff;
      sample_in = sample_ff;
      sts.done  = 1'b0;
      case (state_ff)
         E_IDLE: begin
            if (ctl.go) begin
               pass_in  = 1'b0;
               state_in = E_LOAD;
            end
         end
         E_LOAD: begin
            x_in     = x_new;
            q_in     = ph_sel[PHASE_BITS-1:QBITS];
            state_in = E_SQ;
         end
         E_SQ: begin
            state_in = E_SQ_USE;
         end
         E_SQ_USE: begin
            x2_in    = prod[2*FX_BITS:FX_BITS];
            p_in     = twsg_coef(3'd0);
            k_in     = 3'd0;
            state_in = E_HORN;
         end
         E_HORN: begin
            state_in = E_HORN_USE;
         end
         E_HORN_USE: begin
            p_in = twsg_coef(k_ff + 3'd1) - prod[FX_BITS+MUL_W-1:FX_BITS];
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd4) begin
               state_in = E_FIN;
            end else begin
               state_in = E_HORN;
            end
         end
         E_FIN: begin
            state_in = E_FIN_USE;
         end
         E_FIN_USE: begin
            if (!pass_ff) begin
               smag_in = s_mag;
               sneg_in = fin_neg;
               case (ctl.win)
                  WIN_RISE: begin
                     cph_in   = taper_phase + QUARTER;
                     pass_in  = 1'b1;
                     state_in = E_LOAD;
                  end
                  WIN_FALL: begin
                     acc_in   = '0;
                     bit_in   = BIT_W'(CNT_W - 1);
                     state_in = E_OFFS;
                  end
                  default: begin
                     w_in     = ONE;
                     state_in = E_AMP1;
                  end
               endcase
            end else begin
               w_in     = w_calc;
               pass_in  = 1'b0;
               state_in = E_AMP1;
            end
         end
         E_OFFS: begin
            acc_in = acc_next;
            if (bit_ff == '0) begin
               state_in = E_PHI;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         E_PHI: begin
            // Falling taper runs the cosine at (n - (N-1)) taper steps.
            cph_in   = taper_phase - acc_ff + QUARTER;
            pass_in  = 1'b1;
            state_in = E_LOAD;
         end
         E_AMP1: begin
            state_in = E_AMP1_USE;
         end
         E_AMP1_USE: begin
            m_in     = rnd[VALUE_BITS-1:0];
            state_in = E_AMP2;
         end
         E_AMP2: begin
            state_in = E_AMP2_USE;
         end
         E_AMP2_USE: begin
            sample_in = neg_out ? (~r_mag + 1'b1) : r_mag;
            sts.done  = 1'b1;
            state_in  = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   assign sample   = sample_ff;
   assign envelope = w_ff;

   a_go_when_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.go |-> state_ff == E_IDLE)
      else $error("engine started while busy");

   a_horner_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == E_HORN_USE |-> k_ff <= 3'd4)
      else $error("Horner step count overran");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> state_ff == E_IDLE)
      else $error("engine did not return to idle after done");

endmodule
